>>> sv/tasms_pkg.sv
// Shared types and constants of the two-axis stepper move sequencer.
package tasms_pkg;

  localparam int DEF_COORD_BITS = 8;
  localparam int DEF_COUNT_BITS = 18;

  localparam int FUNC_W  = 2;
  localparam int JOG_W   = 3;
  localparam int SPU_W   = 10;
  localparam int START_W = 16;
  localparam int CFG_W   = START_W;
  localparam int CFG_IDX_W = 1;

  // Steps per unit after reset, and the go-to-start distance:
  // 13 units of travel, two pulses' worth per unit.
  localparam int SPU_RESET   = 320;
  localparam int HOME_UNITS  = 13;
  localparam int START_RESET = HOME_UNITS * SPU_RESET * 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPU   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START = 1'b1;

  // Entries of the queue between decode and execution.
  localparam int QDEPTH = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK = 2'd0,
    FUNC_JOG  = 2'd1,
    FUNC_MOVE = 2'd2,
    FUNC_HOME = 2'd3
  } func_t;

  typedef enum logic [JOG_W-1:0] {
    JOG_BOTH_FWD  = 3'd0,
    JOG_BOTH_BACK = 3'd1,
    JOG_X_BACK    = 3'd2,
    JOG_X_FWD     = 3'd3,
    JOG_Y_FWD     = 3'd4,
    JOG_Y_BACK    = 3'd5
  } jog_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_BOTH     = 3'd1,
    PH_X        = 3'd2,
    PH_Y        = 3'd3,
    PH_X_THEN_Y = 3'd4,
    PH_START    = 3'd5
  } phase_t;

  localparam logic DIR_FWD  = 1'b0;
  localparam logic DIR_BACK = 1'b1;

  // Decoded command as it travels through the queue.
  typedef struct packed {
    func_t  func;
    logic   jog_ok;
    phase_t jog_phase;
    logic   x_dir_we;
    logic   x_dir;
    logic   y_dir_we;
    logic   y_dir;
  } cmd_t;

endpackage

>>> sv/tasms_front.sv
// Front end: classifies an incoming item and decodes the jog code.
module tasms_front
  import tasms_pkg::*;
(
  input  logic [FUNC_W-1:0] func,
  input  logic [JOG_W-1:0]  jog_code,
  output cmd_t              cmd
);

  always_comb begin
    cmd           = '0;
    cmd.func      = func_t'(func);
    cmd.jog_phase = PH_IDLE;
    unique case (jog_code)
      JOG_BOTH_FWD: begin
        cmd.jog_ok = 1'b1; cmd.jog_phase = PH_BOTH;
        cmd.x_dir_we = 1'b1; cmd.x_dir = DIR_FWD;
        cmd.y_dir_we = 1'b1; cmd.y_dir = DIR_FWD;
      end
      JOG_BOTH_BACK: begin
        cmd.jog_ok = 1'b1; cmd.jog_phase = PH_BOTH;
        cmd.x_dir_we = 1'b1; cmd.x_dir = DIR_BACK;
        cmd.y_dir_we = 1'b1; cmd.y_dir = DIR_BACK;
      end
      JOG_X_BACK: begin
        cmd.jog_ok = 1'b1; cmd.jog_phase = PH_X;
        cmd.x_dir_we = 1'b1; cmd.x_dir = DIR_BACK;
      end
      JOG_X_FWD: begin
        cmd.jog_ok = 1'b1; cmd.jog_phase = PH_X;
        cmd.x_dir_we = 1'b1; cmd.x_dir = DIR_FWD;
      end
      JOG_Y_FWD: begin
        cmd.jog_ok = 1'b1; cmd.jog_phase = PH_Y;
        cmd.y_dir_we = 1'b1; cmd.y_dir = DIR_FWD;
      end
      JOG_Y_BACK: begin
        cmd.jog_ok = 1'b1; cmd.jog_phase = PH_Y;
        cmd.y_dir_we = 1'b1; cmd.y_dir = DIR_BACK;
      end
      default: begin
        // unused codes are taken while idle and do nothing
        cmd.jog_ok = 1'b0;
      end
    endcase
  end

endmodule

>>> sv/tasms_queue.sv
// Short FIFO between the decode front end and the execution back end.
module tasms_queue
  import tasms_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem [QDEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(QDEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full      = (count == CW'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      priority if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> sv/tasms_back.sv
// Back end: move state, step counters and the registered result.
module tasms_back
  import tasms_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [SPU_W-1:0]      steps_per_unit,
  input  logic [START_W-1:0]    start_steps,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  input  logic [COORD_BITS-1:0] goal_x,
  input  logic [COORD_BITS-1:0] goal_y,
  output logic                  cmd_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_x_step,
  output logic                  res_x_dir,
  output logic                  res_y_step,
  output logic                  res_y_dir,
  output logic                  res_busy,
  output logic                  res_rejected,
  output logic [COORD_BITS-1:0] res_pos_x,
  output logic [COORD_BITS-1:0] res_pos_y
);

  localparam int PW = COORD_BITS + SPU_W;

  phase_t                phase, phase_next;
  logic [COORD_BITS-1:0] coord_x, coord_x_next;
  logic [COORD_BITS-1:0] coord_y, coord_y_next;
  logic                  x_step_level, x_step_level_next;
  logic                  y_step_level, y_step_level_next;
  logic                  x_dir_level, x_dir_level_next;
  logic                  y_dir_level, y_dir_level_next;
  logic [COUNT_BITS-1:0] steps_left, steps_left_next;
  logic [COUNT_BITS-1:0] y_steps_pending, y_steps_pending_next;
  logic                  rejected_next;

  logic                  fire;
  logic                  idle;
  logic                  x_gt, x_lt, y_gt, y_lt;
  logic [COORD_BITS-1:0] dist_x, dist_y;
  logic [PW-1:0]         prod_x, prod_y;
  logic [COUNT_BITS-1:0] steps_x, steps_y;
  logic [COUNT_BITS-1:0] spu_n, start_n, left_dec;

  // output stage can take a new result when empty or being drained
  assign fire    = cmd_valid && (!res_valid || res_ready);
  assign cmd_pop = fire;
  assign idle    = (phase == PH_IDLE);

  assign x_gt   = goal_x > coord_x;
  assign x_lt   = goal_x < coord_x;
  assign y_gt   = goal_y > coord_y;
  assign y_lt   = goal_y < coord_y;
  assign dist_x = x_gt ? goal_x - coord_x : coord_x - goal_x;
  assign dist_y = y_gt ? goal_y - coord_y : coord_y - goal_y;
  assign prod_x = PW'(dist_x) * PW'(steps_per_unit);
  assign prod_y = PW'(dist_y) * PW'(steps_per_unit);

  // saturate step counts at the counter width
  assign steps_x = ((prod_x >> COUNT_BITS) != '0) ? '1 : COUNT_BITS'(prod_x);
  assign steps_y = ((prod_y >> COUNT_BITS) != '0) ? '1 : COUNT_BITS'(prod_y);

  assign spu_n    = COUNT_BITS'(steps_per_unit);
  assign start_n  = COUNT_BITS'(start_steps);
  assign left_dec = (steps_left != '0) ? steps_left - COUNT_BITS'(1) : steps_left;

  always_comb begin
    phase_next           = phase;
    coord_x_next         = coord_x;
    coord_y_next         = coord_y;
    x_step_level_next    = x_step_level;
    y_step_level_next    = y_step_level;
    x_dir_level_next     = x_dir_level;
    y_dir_level_next     = y_dir_level;
    steps_left_next      = steps_left;
    y_steps_pending_next = y_steps_pending;
    rejected_next        = 1'b0;

    if (cmd.func == FUNC_TICK) begin
      if (!idle) begin
        if (phase == PH_BOTH || phase == PH_START || phase == PH_X ||
            phase == PH_X_THEN_Y) begin
          x_step_level_next = !x_step_level;
        end
        if (phase == PH_BOTH || phase == PH_START || phase == PH_Y) begin
          y_step_level_next = !y_step_level;
        end
        steps_left_next = left_dec;
        if (left_dec == '0) begin
          priority if (phase == PH_X_THEN_Y && y_steps_pending != '0) begin
            steps_left_next      = y_steps_pending;
            y_steps_pending_next = '0;
            phase_next           = PH_Y;
          end else begin
            if (phase == PH_START) begin
              coord_x_next = '0;
              coord_y_next = '0;
            end
            y_steps_pending_next = '0;
            phase_next           = PH_IDLE;
          end
        end
      end
    end else if (!idle) begin
      rejected_next = 1'b1;
    end else begin
      unique case (cmd.func)
        FUNC_JOG: begin
          if (cmd.jog_ok && spu_n != '0) begin
            if (cmd.x_dir_we) x_dir_level_next = cmd.x_dir;
            if (cmd.y_dir_we) y_dir_level_next = cmd.y_dir;
            phase_next      = cmd.jog_phase;
            steps_left_next = spu_n;
          end
        end
        FUNC_MOVE: begin
          coord_x_next = goal_x;
          coord_y_next = goal_y;
          // a zero count leaves the direction line as it was
          if ((x_gt || x_lt) && steps_x != '0) x_dir_level_next = x_lt;
          if ((y_gt || y_lt) && steps_y != '0) y_dir_level_next = y_lt;
          priority if ((x_gt || x_lt) && steps_x != '0) begin
            steps_left_next      = steps_x;
            y_steps_pending_next = (y_gt || y_lt) ? steps_y : '0;
            phase_next           = PH_X_THEN_Y;
          end else if ((y_gt || y_lt) && steps_y != '0) begin
            steps_left_next      = steps_y;
            y_steps_pending_next = '0;
            phase_next           = PH_Y;
          end
        end
        FUNC_HOME: begin
          if (start_n == '0) begin
            coord_x_next = '0;
            coord_y_next = '0;
          end else begin
            x_dir_level_next = DIR_FWD;
            y_dir_level_next = DIR_FWD;
            steps_left_next  = start_n;
            phase_next       = PH_START;
          end
        end
        default: begin
          // ticks are handled above
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      coord_x         <= '0;
      coord_y         <= '0;
      x_step_level    <= 1'b0;
      y_step_level    <= 1'b0;
      x_dir_level     <= DIR_FWD;
      y_dir_level     <= DIR_FWD;
      steps_left      <= '0;
      y_steps_pending <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      coord_x         <= coord_x_next;
      coord_y         <= coord_y_next;
      x_step_level    <= x_step_level_next;
      y_step_level    <= y_step_level_next;
      x_dir_level     <= x_dir_level_next;
      y_dir_level     <= y_dir_level_next;
      steps_left      <= steps_left_next;
      y_steps_pending <= y_steps_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_x_step   <= x_step_level_next;
      res_x_dir    <= x_dir_level_next;
      res_y_step   <= y_step_level_next;
      res_y_dir    <= y_dir_level_next;
      res_busy     <= (phase_next != PH_IDLE);
      res_rejected <= rejected_next;
      res_pos_x    <= coord_x_next;
      res_pos_y    <= coord_y_next;
    end
  end

endmodule

>>> sv/two_axis_stepper_move_sequencer_core.sv
// Top level of the two-axis stepper move sequencer.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+------------------------------------
//  s_axis   | in  | s_tvalid / s_tready      | tuser func; tdata jog, goal x, y
//  m_axis   | out | m_tvalid / m_tready      | tdata steps, dirs, flags, coords
//  cfg      | in  | cfg_we                   | cfg_addr, cfg_wdata
//
// One item per clock sustained while m_tready stays high; m_tvalid rises once an
// item has passed the queue and the output register. The back end executes each
// item against the move state; a two-entry queue and the output register let input
// and output stall apart. Synchronous reset empties the queue, drops m_tvalid and
// restores the settings and move state. s_tready falls only while the queue is full.
module two_axis_stepper_move_sequencer_core
  import tasms_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  localparam int IN_W  = ((JOG_W + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((6 + 2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // jog_code, goal_x, goal_y
  input  logic [FUNC_W-1:0]    s_tuser,   // func
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // x_step, x_dir, y_step, y_dir, busy_res, rejected, pos_x, pos_y
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int QW = $bits(cmd_t) + 2 * COORD_BITS;

  logic [SPU_W-1:0]      steps_per_unit;
  logic [START_W-1:0]    start_steps;
  cmd_t                  front_cmd;
  cmd_t                  q_cmd;
  logic [QW-1:0]         q_head;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  logic                  push;
  logic [COORD_BITS-1:0] q_goal_x, q_goal_y;
  logic                  r_x_step, r_x_dir, r_y_step, r_y_dir, r_busy, r_rej;
  logic [COORD_BITS-1:0] r_pos_x, r_pos_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_unit <= SPU_W'(SPU_RESET);
      start_steps    <= START_W'(START_RESET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SPU:   steps_per_unit <= cfg_wdata[SPU_W-1:0];
        REG_START: start_steps    <= cfg_wdata[START_W-1:0];
      endcase
    end
  end

  tasms_front u_front (
    .func     (s_tuser),
    .jog_code (s_tdata[JOG_W-1:0]),
    .cmd      (front_cmd)
  );

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  tasms_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({s_tdata[JOG_W+2*COORD_BITS-1:JOG_W], front_cmd}),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  assign q_cmd    = q_head[$bits(cmd_t)-1:0];
  assign q_goal_x = q_head[$bits(cmd_t)+COORD_BITS-1:$bits(cmd_t)];
  assign q_goal_y = q_head[QW-1:$bits(cmd_t)+COORD_BITS];

  tasms_back #(.COORD_BITS(COORD_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .steps_per_unit (steps_per_unit),
    .start_steps    (start_steps),
    .cmd_valid      (q_not_empty),
    .cmd            (q_cmd),
    .goal_x         (q_goal_x),
    .goal_y         (q_goal_y),
    .cmd_pop        (q_pop),
    .res_valid      (m_tvalid),
    .res_ready      (m_tready),
    .res_x_step     (r_x_step),
    .res_x_dir      (r_x_dir),
    .res_y_step     (r_y_step),
    .res_y_dir      (r_y_dir),
    .res_busy       (r_busy),
    .res_rejected   (r_rej),
    .res_pos_x      (r_pos_x),
    .res_pos_y      (r_pos_y)
  );

  assign m_tdata = OUT_W'({r_pos_y, r_pos_x, r_rej, r_busy,
                           r_y_dir, r_y_step, r_x_dir, r_x_step});

endmodule

>>> sv/tasms_chk.sv
// Port-level checker for the sequencer core, bound to the top level.
module tasms_chk
  import tasms_pkg::*;
#(
  parameter int OUT_W = 24
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam int BUSY_BIT = 4;
  localparam int REJ_BIT  = 5;

  // items taken in but not yet delivered
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'((s_tvalid && s_tready) ? 1 : 0)
                         - 3'((m_tvalid && m_tready) ? 1 : 0);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != '0)
    else $error("result without a pending item");

  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[REJ_BIT] |-> m_tdata[BUSY_BIT])
    else $error("rejected command reported while idle");

endmodule

bind two_axis_stepper_move_sequencer_core tasms_chk #(.OUT_W(OUT_W)) u_tasms_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/two_axis_stepper_move_sequencer_core_test.sv
// Self-checking testbench for the two-axis stepper move sequencer core.
module two_axis_stepper_move_sequencer_core_test;
  import tasms_pkg::*;

  localparam int CRD_W = DEF_COORD_BITS;
  localparam int CNT_W = DEF_COUNT_BITS;
  localparam longint CNT_MAX = (64'd1 << CNT_W) - 1;
  localparam int IN_W  = ((JOG_W + 2 * CRD_W + 7) / 8) * 8;
  localparam int OUT_W = ((6 + 2 * CRD_W + 7) / 8) * 8;

  // jog codes outside the defined set, accepted and ignored while idle
  localparam logic [JOG_W-1:0] JOG_SPARE_6 = 3'd6;
  localparam logic [JOG_W-1:0] JOG_SPARE_7 = 3'd7;

  // last field in the lowest bits, as on m_tdata
  typedef struct packed {
    logic [CRD_W-1:0] pos_y;
    logic [CRD_W-1:0] pos_x;
    logic             rejected;
    logic             busy_res;
    logic             y_dir;
    logic             y_step;
    logic             x_dir;
    logic             x_step;
  } motion_t;

  typedef struct {
    func_t            f;
    logic [JOG_W-1:0] jc;
    logic [CRD_W-1:0] gx;
    logic [CRD_W-1:0] gy;
    logic             typed;
    motion_t          want;
  } seq_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // jog_code, goal_x, goal_y
  logic [FUNC_W-1:0] s_tuser = FUNC_TICK; // func
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // x_step, x_dir, y_step, y_dir, busy_res, rejected, pos_x, pos_y
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = REG_SPU;
  logic [CFG_W-1:0] cfg_wdata = '0;

  two_axis_stepper_move_sequencer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #30000000;
    $display("two_axis_stepper_move_sequencer_core_test: errors");
    $finish;
  end

  // Predicted sequencer state and settings
  logic [SPU_W-1:0]   spu        = SPU_RESET;
  logic [START_W-1:0] home_steps = START_RESET;
  logic [CRD_W-1:0]   crd_x = '0, crd_y = '0;
  logic               lvl_x = 1'b0, lvl_y = 1'b0;
  logic               dir_x = DIR_FWD, dir_y = DIR_FWD;
  phase_t             ph = PH_IDLE;
  logic [CNT_W-1:0]   steps_left = '0;
  logic [CNT_W-1:0]   y_queued = '0;

  motion_t motion_q[$];
  bit      pace_on = 1'b1;
  int      errors = 0;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_refused = 0;

  function automatic logic [CNT_W-1:0] clip_count(longint v);
    return (v > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : v[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] axis_steps(logic [CRD_W-1:0] goal,
                                                  logic [CRD_W-1:0] at);
    longint span;
    span = (goal > at) ? goal - at : at - goal;
    return clip_count(span * spu);
  endfunction

  function automatic void tick_axes();
    logic mx, my;
    case (ph)
      PH_BOTH, PH_START: begin mx = 1'b1; my = 1'b1; end
      PH_X, PH_X_THEN_Y: begin mx = 1'b1; my = 1'b0; end
      PH_Y: begin mx = 1'b0; my = 1'b1; end
      default: return;
    endcase
    if (mx) lvl_x = ~lvl_x;
    if (my) lvl_y = ~lvl_y;
    if (steps_left != 0) steps_left = steps_left - 1'b1;
    if (steps_left != 0) return;
    if (ph == PH_X_THEN_Y && y_queued != 0) begin
      steps_left = y_queued;
      y_queued = '0;
      ph = PH_Y;
      return;
    end
    if (ph == PH_START) begin
      crd_x = '0;
      crd_y = '0;
    end
    y_queued = '0;
    ph = PH_IDLE;
  endfunction

  function automatic void start_jog(logic [JOG_W-1:0] jc);
    logic [CNT_W-1:0] n;
    n = clip_count(spu);
    if (n == 0 || jc > JOG_Y_BACK) return;
    case (jc)
      JOG_BOTH_FWD:  begin dir_x = DIR_FWD;  dir_y = DIR_FWD;  ph = PH_BOTH; end
      JOG_BOTH_BACK: begin dir_x = DIR_BACK; dir_y = DIR_BACK; ph = PH_BOTH; end
      JOG_X_BACK:    begin dir_x = DIR_BACK; ph = PH_X; end
      JOG_X_FWD:     begin dir_x = DIR_FWD;  ph = PH_X; end
      JOG_Y_FWD:     begin dir_y = DIR_FWD;  ph = PH_Y; end
      default:       begin dir_y = DIR_BACK; ph = PH_Y; end
    endcase
    steps_left = n;
  endfunction

  function automatic void start_move(logic [CRD_W-1:0] gx, logic [CRD_W-1:0] gy);
    logic [CNT_W-1:0] sx, sy;
    sx = axis_steps(gx, crd_x);
    sy = axis_steps(gy, crd_y);
    // y direction is set now, not when y starts stepping
    if (sx != 0) dir_x = (gx < crd_x) ? DIR_BACK : DIR_FWD;
    if (sy != 0) dir_y = (gy < crd_y) ? DIR_BACK : DIR_FWD;
    crd_x = gx;
    crd_y = gy;
    if (sx != 0) begin
      steps_left = sx;
      y_queued = sy;
      ph = PH_X_THEN_Y;
    end else if (sy != 0) begin
      steps_left = sy;
      y_queued = '0;
      ph = PH_Y;
    end
  endfunction

  function automatic void start_home();
    if (home_steps == 0) begin
      crd_x = '0;
      crd_y = '0;
      return;
    end
    dir_x = DIR_FWD;
    dir_y = DIR_FWD;
    steps_left = clip_count(home_steps);
    ph = PH_START;
  endfunction

  function automatic motion_t predict_motion(func_t f, logic [JOG_W-1:0] jc,
                                             logic [CRD_W-1:0] gx, logic [CRD_W-1:0] gy);
    motion_t r;
    logic rej;
    rej = 1'b0;
    if (f == FUNC_TICK) tick_axes();
    else if (ph != PH_IDLE) rej = 1'b1;
    else if (f == FUNC_JOG) start_jog(jc);
    else if (f == FUNC_MOVE) start_move(gx, gy);
    else start_home();
    r.x_step   = lvl_x;
    r.x_dir    = dir_x;
    r.y_step   = lvl_y;
    r.y_dir    = dir_y;
    r.busy_res = (ph != PH_IDLE);
    r.rejected = rej;
    r.pos_x    = crd_x;
    r.pos_y    = crd_y;
    return r;
  endfunction

  // outputs seen early in the run: only x step, busy and the refusal flag move
  function automatic motion_t x_only(logic xs, logic busy, logic rej);
    motion_t r;
    r = '0;
    r.x_step = xs;
    r.busy_res = busy;
    r.rejected = rej;
    return r;
  endfunction

  function automatic string show(motion_t m);
    return $sformatf("xs=%0d xd=%0d ys=%0d yd=%0d busy=%0d rej=%0d x=%0d y=%0d",
                     m.x_step, m.x_dir, m.y_step, m.y_dir, m.busy_res, m.rejected,
                     m.pos_x, m.pos_y);
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic offer(func_t f, logic [JOG_W-1:0] jc, logic [CRD_W-1:0] gx,
                       logic [CRD_W-1:0] gy, logic typed, motion_t want);
    int gap;
    motion_t m;
    gap = pace_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {{(IN_W - JOG_W - 2 * CRD_W){1'b0}}, gy, gx, jc};
    do @(posedge clk); while (!s_tready);
    m = predict_motion(f, jc, gx, gy);
    if (m.rejected) n_refused++;
    motion_q.push_back(typed ? want : m);
    n_sent++;
  endtask

  task automatic tick_junk();
    offer(FUNC_TICK, JOG_W'($urandom), CRD_W'($urandom), CRD_W'($urandom), 1'b0, '0);
  endtask

  task automatic finish_motion();
    while (ph != PH_IDLE) tick_junk();
  endtask

  // wait until every result is back before touching the registers
  task automatic settle();
    s_tvalid <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(logic [SPU_W-1:0] spu_val, logic [START_W-1:0] start_val);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SPU;
    // bits above the register width are dropped
    cfg_wdata <= {6'($urandom), spu_val};
    @(posedge clk);
    cfg_addr  <= REG_START;
    cfg_wdata <= start_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    spu        = spu_val;
    home_steps = start_val;
  endtask

  function automatic logic [CRD_W-1:0] near_goal(logic [CRD_W-1:0] at);
    int v;
    if (spu <= 2 && $urandom_range(0, 3) == 0) return CRD_W'($urandom);
    v = int'(at) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > (1 << CRD_W) - 1) v = (1 << CRD_W) - 1;
    return v[CRD_W-1:0];
  endfunction

  task automatic random_item();
    int r;
    logic [JOG_W-1:0] jc;
    logic [CRD_W-1:0] gx, gy;
    r  = $urandom_range(0, 99);
    jc = JOG_W'($urandom);
    gx = CRD_W'($urandom);
    gy = CRD_W'($urandom);
    if (ph == PH_IDLE) begin
      if (r < 10) offer(FUNC_TICK, jc, gx, gy, 1'b0, '0);
      else if (r < 35) offer(FUNC_JOG, jc, gx, gy, 1'b0, '0);
      else if (r < 88) offer(FUNC_MOVE, jc, near_goal(crd_x), near_goal(crd_y), 1'b0, '0);
      else offer(FUNC_HOME, jc, gx, gy, 1'b0, '0);
    end else if (r < 90) begin
      offer(FUNC_TICK, jc, gx, gy, 1'b0, '0);
    end else begin
      // command while moving: must be refused
      offer(func_t'($urandom_range(1, 3)), jc, gx, gy, 1'b0, '0);
    end
  endtask

  task automatic run_phase(logic [SPU_W-1:0] spu_val, logic [START_W-1:0] start_val,
                           bit pace, int count);
    settle();
    apply_settings(spu_val, start_val);
    pace_on = pace;
    repeat (count) random_item();
  endtask

  // result checker
  initial begin : sink
    motion_t got, want;
    int stall;
    string diffs;
    while (rst) @(posedge clk);
    forever begin
      // two long hold-offs let the input side back up
      if (n_checked == 300 || n_checked == 900) stall = 60;
      else stall = pace_on ? $urandom_range(0, 5) : 0;
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = motion_t'(m_tdata[$bits(motion_t)-1:0]);
      n_checked++;
      if (motion_q.size() == 0) begin
        note_error($sformatf("result %0d with nothing pending: %s", n_checked, show(got)));
      end else begin
        want = motion_q.pop_front();
        diffs = "";
        if (got.x_step   != want.x_step)   diffs = {diffs, " x_step"};
        if (got.x_dir    != want.x_dir)    diffs = {diffs, " x_dir"};
        if (got.y_step   != want.y_step)   diffs = {diffs, " y_step"};
        if (got.y_dir    != want.y_dir)    diffs = {diffs, " y_dir"};
        if (got.busy_res != want.busy_res) diffs = {diffs, " busy_res"};
        if (got.rejected != want.rejected) diffs = {diffs, " rejected"};
        if (got.pos_x    != want.pos_x)    diffs = {diffs, " pos_x"};
        if (got.pos_y    != want.pos_y)    diffs = {diffs, " pos_y"};
        if (diffs != "")
          note_error($sformatf("result %0d wrong in%s\n  expected %s\n  actual   %s",
                               n_checked, diffs, show(want), show(got)));
      end
    end
  end

  // stimulus
  initial begin : source
    seq_row_t opening[25];
    int i;
    // reset settings: 320 steps per unit, 8320 to start
    opening[0]  = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b1, x_only(0, 0, 0)};
    opening[1]  = '{FUNC_JOG,  JOG_SPARE_6,   8'd0,   8'd0,   1'b1, x_only(0, 0, 0)};
    opening[2]  = '{FUNC_JOG,  JOG_SPARE_7,   8'd255, 8'd255, 1'b1, x_only(0, 0, 0)};
    opening[3]  = '{FUNC_MOVE, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b1, x_only(0, 0, 0)};
    opening[4]  = '{FUNC_JOG,  JOG_X_FWD,     8'd0,   8'd0,   1'b1, x_only(0, 1, 0)};
    opening[5]  = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b1, x_only(1, 1, 0)};
    opening[6]  = '{FUNC_MOVE, JOG_BOTH_FWD,  8'd5,   8'd5,   1'b1, x_only(1, 1, 1)};
    opening[7]  = '{FUNC_HOME, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b1, x_only(1, 1, 1)};
    opening[8]  = '{FUNC_JOG,  JOG_BOTH_FWD,  8'd0,   8'd0,   1'b1, x_only(1, 1, 1)};
    // one step per unit, zero start distance
    opening[9]  = '{FUNC_JOG,  JOG_BOTH_BACK, 8'd0,   8'd0,   1'b0, '0};
    opening[10] = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    opening[11] = '{FUNC_JOG,  JOG_X_BACK,    8'd0,   8'd0,   1'b0, '0};
    opening[12] = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    opening[13] = '{FUNC_JOG,  JOG_Y_FWD,     8'd0,   8'd0,   1'b0, '0};
    opening[14] = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    opening[15] = '{FUNC_JOG,  JOG_Y_BACK,    8'd0,   8'd0,   1'b0, '0};
    opening[16] = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    opening[17] = '{FUNC_MOVE, JOG_BOTH_FWD,  8'd1,   8'd0,   1'b0, '0};
    opening[18] = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    // x back one, then y forward two; y direction flips at once
    opening[19] = '{FUNC_MOVE, JOG_BOTH_FWD,  8'd0,   8'd2,   1'b0, '0};
    opening[20] = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    opening[21] = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    opening[22] = '{FUNC_TICK, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    // zero start distance: coordinates clear at once, stays idle
    opening[23] = '{FUNC_HOME, JOG_BOTH_FWD,  8'd0,   8'd0,   1'b0, '0};
    opening[24] = '{FUNC_MOVE, JOG_BOTH_FWD,  8'd255, 8'd0,   1'b0, '0};

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 25; i++) begin
      if (i == 9) begin
        finish_motion();
        settle();
        apply_settings(10'd1, 16'd0);
      end
      offer(opening[i].f, opening[i].jc, opening[i].gx, opening[i].gy,
            opening[i].typed, opening[i].want);
    end
    finish_motion();

    run_phase(10'd1, 16'd5,  1'b1, 200);
    run_phase(10'd2, 16'd1,  1'b0, 150);
    run_phase(10'd0, 16'd4,  1'b1, 100);
    run_phase(10'd3, 16'd17, 1'b1, 200);
    run_phase(10'd5, 16'd320, 1'b1, 150);

    // widest settings; the x leg of this move loads a count past 16 bits and
    // keeps the block busy to the end, so later commands are refused
    run_phase(10'd1023, 16'd65535, 1'b0, 0);
    finish_motion();
    offer(FUNC_MOVE, JOG_BOTH_FWD, 8'd65, 8'd1, 1'b0, '0);
    repeat (40) random_item();

    settle();
    repeat (10) @(posedge clk);
    errors += motion_q.size();
    $display("%0d items in, %0d results checked, %0d commands refused mid-move",
             n_sent, n_checked, n_refused);
    $display("steps per unit 0..1023 and start distances 0..65535, stalls on both sides");
    if (errors == 0) begin
      $display("two_axis_stepper_move_sequencer_core_test: clean");
    end else begin
      $display("two_axis_stepper_move_sequencer_core_test: errors");
    end
    $finish;
  end

endmodule
